// ----- rtl/edmc_pkg.sv -----
package edmc_pkg;

    // Frame geometry limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int THR_W      = 8;
    localparam int DIM_W      = 11;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Output queue (depth must be a power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [PIX_W-1:0] WHITE_RGB = 24'hFFFFFF;
    localparam logic [PIX_W-1:0] BLACK_RGB = 24'h000000;

    // Per-request window control: which neighbor rows/columns lie inside the frame
    typedef struct packed {
        logic produce;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic frame_last;
    } win_ctl_t;

    // Result leaving the window stage
    typedef struct packed {
        logic valid;
        logic edge_found;
        logic frame_last;
    } win_rsp_t;

    // One queued result
    typedef struct packed {
        logic edge_found;
        logic frame_last;
    } out_item_t;

    // True when any color channel of a and b differs by more than thr
    function automatic logic gap_exceeds(input logic [PIX_W-1:0] a,
                                         input logic [PIX_W-1:0] b,
                                         input logic [THR_W-1:0] thr);
        logic              hit;
        logic [CHAN_W-1:0] x;
        logic [CHAN_W-1:0] y;
        logic [CHAN_W-1:0] d;
        hit = 1'b0;
        for (int k = 0; k < PIX_W / CHAN_W; k++) begin
            x = a[k*CHAN_W +: CHAN_W];
            y = b[k*CHAN_W +: CHAN_W];
            d = (x > y) ? (x - y) : (y - x);
            if (d > thr) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ----- rtl/edge_detect_max_channel_3x3_core.sv -----
// Streaming 3x3 edge detector on 24-bit RGB pixels in raster order. A pixel is
// marked an edge (0x000000, m_tuser high) when any in-frame neighbor differs
// from it by more than threshold in some color channel, otherwise it comes out
// white (0xFFFFFF). Results trail the input by image_width+1 pixels; send that
// many flush requests (s_tuser high) after a frame to drain it, and the last
// result of the frame carries m_tlast. One request is taken every clock cycle
// while s_tready is high, a rate set by the two line-store RAMs, each read and
// written once per cycle, with forwarding between adjacent requests that hit
// the same column. The result of the request that completes a window passes
// the memory stage, the window registers and the output queue to the m_ side.
// The four-entry output queue absorbs stalls on the m_ side; s_tready drops only
// while that queue and the results in flight would fill it. Line stores need
// no clearing after reset. Write geometry and threshold between frames.
module edge_detect_max_channel_3x3_core
    import edmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // [23:0] pixel
    input  logic                  s_tuser,   // [0] command (flush)
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIX_W-1:0]      m_tdata,   // [23:0] pixel_out
    output logic                  m_tuser,   // [0] edge_found
    output logic                  m_tlast    // frame_last
);

    // Configuration registers
    logic [THR_W-1:0] threshold_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Frame position and results owed
    logic [DIM_W-1:0] col_reg,     col_next;
    logic [DIM_W-1:0] row_reg,     row_next;
    logic [DIM_W-1:0] pending_reg, pending_next;

    // Request in the memory stage
    logic              p1_valid_reg;
    logic [ADDR_W-1:0] p1_addr_reg;
    logic [PIX_W-1:0]  p1_pix_reg;
    logic              p1_fwd_reg;
    logic [PIX_W-1:0]  p1_fwd_top_reg;
    logic [PIX_W-1:0]  p1_fwd_mid_reg;
    win_ctl_t          p1_ctl_reg;

    logic [DIM_W-1:0]  w_cl;
    logic [DIM_W-1:0]  h_cl;
    logic              s_accept;
    logic              full;
    logic              drop_rst;
    logic              ignore;
    logic              take;
    logic [PIX_W-1:0]  pix_in;
    logic [ADDR_W-1:0] rd_addr;
    logic              fwd_hit;
    win_ctl_t          ctl_s0;
    logic [DIM_W:0]    col_inc;
    logic              col_wrap;
    logic [DIM_W-1:0]  pend_a;
    logic [DIM_W-1:0]  pend_b;

    logic [PIX_W-1:0]  top_q;
    logic [PIX_W-1:0]  mid_q;
    logic [PIX_W-1:0]  top_eff;
    logic [PIX_W-1:0]  mid_eff;

    win_rsp_t              rsp;
    out_item_t             push_item;
    out_item_t             head_item;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W-1:0] in_flight;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            width_reg     <= DIM_W'(MAX_WIDTH);
            height_reg    <= DIM_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_THRESHOLD:    threshold_reg <= cfg_wdata[THR_W-1:0];
                REG_IMAGE_WIDTH:  width_reg     <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp geometry to the supported range
    always_comb begin
        if (width_reg == '0) begin
            w_cl = DIM_W'(1);
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            w_cl = DIM_W'(MAX_WIDTH);
        end else begin
            w_cl = width_reg;
        end
        if (height_reg == '0) begin
            h_cl = DIM_W'(1);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            h_cl = DIM_W'(MAX_HEIGHT);
        end else begin
            h_cl = height_reg;
        end
    end

    // Classify the incoming request and build its window control
    always_comb begin
        s_accept = s_tvalid && s_tready;
        full     = (row_reg >= h_cl);
        drop_rst = full && (pending_reg == '0);
        ignore   = !full && s_tuser;
        take     = s_accept && !drop_rst && !ignore;
        pix_in   = full ? '0 : s_tdata;

        if (col_reg > DIM_W'(MAX_WIDTH - 1)) begin
            rd_addr = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            rd_addr = col_reg[ADDR_W-1:0];
        end
        fwd_hit = p1_valid_reg && (p1_addr_reg == rd_addr);

        ctl_s0.produce  = (row_reg >= DIM_W'(2)) ||
                          ((row_reg == DIM_W'(1)) && (col_reg != '0));
        ctl_s0.top_ok   = (col_reg == '0) ? (row_reg != DIM_W'(2)) : (row_reg != DIM_W'(1));
        ctl_s0.bot_ok   = (col_reg == '0) ? (row_reg <= h_cl) : (row_reg < h_cl);
        ctl_s0.left_ok  = (col_reg == '0) ? (w_cl != DIM_W'(1)) : (col_reg != DIM_W'(1));
        ctl_s0.right_ok = (col_reg != '0) && (col_reg < w_cl);

        col_inc  = {1'b0, col_reg} + (DIM_W+1)'(1);
        col_wrap = (col_inc >= {1'b0, w_cl});
        pend_a   = full ? pending_reg : (pending_reg + DIM_W'(1));
        pend_b   = (ctl_s0.produce && (pend_a != '0)) ? (pend_a - DIM_W'(1)) : pend_a;
        ctl_s0.frame_last = ctl_s0.produce && full && (pend_b == '0);
    end

    // Advance frame position and owed count
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        if (s_accept && drop_rst) begin
            col_next = '0;
            row_next = '0;
        end else if (take) begin
            pending_next = pend_b;
            if (ctl_s0.frame_last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_wrap) begin
                col_next = '0;
                row_next = row_reg + DIM_W'(1);
            end else begin
                col_next = col_inc[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            pending_reg  <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pending_reg  <= pending_next;
            p1_valid_reg <= take;
        end
    end

    // Hold the request while the line stores are read; capture forwarded data
    always_ff @(posedge aclk) begin
        if (take) begin
            p1_addr_reg    <= rd_addr;
            p1_pix_reg     <= pix_in;
            p1_ctl_reg     <= ctl_s0;
            p1_fwd_reg     <= fwd_hit;
            p1_fwd_top_reg <= mid_eff;
            p1_fwd_mid_reg <= p1_pix_reg;
        end
    end

    // Pick stored or forwarded column data
    assign top_eff = p1_fwd_reg ? p1_fwd_top_reg : top_q;
    assign mid_eff = p1_fwd_reg ? p1_fwd_mid_reg : mid_q;

    // Line stores: read at accept, write back in the cycle after
    edmc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_above_ram (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata (mid_eff),
        .raddr (rd_addr),
        .rdata (top_q)
    );

    edmc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_ram (
        .aclk  (aclk),
        .we    (p1_valid_reg),
        .waddr (p1_addr_reg),
        .wdata (p1_pix_reg),
        .raddr (rd_addr),
        .rdata (mid_q)
    );

    edmc_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (p1_valid_reg),
        .col_top   (top_eff),
        .col_mid   (mid_eff),
        .col_pix   (p1_pix_reg),
        .ctl_in    (p1_ctl_reg),
        .threshold (threshold_reg),
        .rsp       (rsp)
    );

    assign push_item.edge_found = rsp.edge_found;
    assign push_item.frame_last = rsp.frame_last;

    edmc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rsp.valid),
        .push_item (push_item),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_item  (head_item),
        .count     (fifo_count)
    );

    // Accept only while the queue has room for everything in flight plus one
    always_comb begin
        in_flight = FIFO_CNT_W'(p1_valid_reg && p1_ctl_reg.produce) +
                    FIFO_CNT_W'(rsp.valid);
        s_tready  = ((fifo_count + in_flight) <= FIFO_CNT_W'(FIFO_DEPTH - 1));
    end

    assign m_tdata = head_item.edge_found ? BLACK_RGB : WHITE_RGB;
    assign m_tuser = head_item.edge_found;
    assign m_tlast = head_item.frame_last;

    // Last result of a frame returns the position to the frame start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && p1_ctl_reg.frame_last) |-> (col_reg == '0 && row_reg == '0))
        else $error("frame end did not rewind position");

    // Back-to-back requests on one column must use forwarded data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && $past(p1_valid_reg) && (p1_addr_reg == $past(p1_addr_reg)))
            |-> p1_fwd_reg)
        else $error("missed line-store forwarding");

endmodule

// ----- rtl/edmc_ram.sv -----
module edmc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered output
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/edmc_window.sv -----
module edmc_window
    import edmc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  logic [PIX_W-1:0] col_top,
    input  logic [PIX_W-1:0] col_mid,
    input  logic [PIX_W-1:0] col_pix,
    input  win_ctl_t         ctl_in,
    input  logic [THR_W-1:0] threshold,
    output win_rsp_t         rsp
);

    logic [PIX_W-1:0] win_reg [9];
    logic             p2_valid_reg;
    win_ctl_t         p2_ctl_reg;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic             hit;

    // Shift the 3x3 window one column left, new column enters on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3 + 0] <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= col_top;
            win_reg[5] <= col_mid;
            win_reg[8] <= col_pix;
        end
    end

    // Track the request whose window is now in place
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= shift_en && ctl_in.produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            p2_ctl_reg <= ctl_in;
        end
    end

    // Compare the center against every in-frame neighbor
    always_comb begin
        row_ok = {p2_ctl_reg.bot_ok, 1'b1, p2_ctl_reg.top_ok};
        col_ok = {p2_ctl_reg.right_ok, 1'b1, p2_ctl_reg.left_ok};
        hit    = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c] && gap_exceeds(win_reg[4], win_reg[r*3 + c], threshold))
                begin
                    hit = 1'b1;
                end
            end
        end
    end

    assign rsp.valid      = p2_valid_reg;
    assign rsp.edge_found = hit;
    assign rsp.frame_last = p2_ctl_reg.frame_last;

    // A result always comes from a window shifted in the cycle before
    assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> $past(shift_en))
        else $error("window result without a preceding shift");

endmodule

// ----- rtl/edmc_out_fifo.sv -----
module edmc_out_fifo
    import edmc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  out_item_t             push_item,
    input  logic                  pop,
    output logic                  out_valid,
    output out_item_t             out_item,
    output logic [FIFO_CNT_W-1:0] count
);

    out_item_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    do_pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && out_valid;

    // Store incoming results
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end else if (!push && do_pop) begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    // Credit scheme must never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule
